[rtl/tlpc_pkg.sv]
package tlpc_pkg;

    // Highest filter order and the widths that follow from it.
    localparam int MAX_ORDER = 20;
    localparam int IDX_W     = $clog2(MAX_ORDER);
    localparam int ORD_W     = $clog2(MAX_ORDER + 1);

    // Datapath widths: LPC taps are Q23.24 in 48 bits, samples Q15.16 in 32 bits.
    localparam int LPC_W  = 48;
    localparam int SMP_W  = 32;
    localparam int K_W    = 25;
    localparam int PH_W   = 24 + SMP_W;
    localparam int PL_W   = 25 + SMP_W;
    localparam int ACC_W  = PL_W + ORD_W;

    // Operation codes carried in tuser.
    localparam logic [1:0] OP_BEGIN  = 2'd0;
    localparam logic [1:0] OP_LOAD   = 2'd1;
    localparam logic [1:0] OP_FILTER = 2'd2;

    // Reflection coefficient in Q.24 for a quantized index.
    function automatic logic signed [K_W-1:0] refl_coef(input logic res3,
                                                       input logic [3:0] q);
        logic signed [K_W-1:0] k;
        k = '0;
        if (res3)
        begin
            case (q[2:0])
                3'd0: k = 25'sd0;
                3'd1: k = 25'sd7279361;
                3'd2: k = 25'sd13116956;
                3'd3: k = 25'sd16356576;
                3'd4: k = -25'sd16522332;
                3'd5: k = -25'sd14529495;
                3'd6: k = -25'sd10784187;
                default: k = -25'sd5738146;
            endcase
        end
        else
        begin
            case (q)
                4'd0:  k = 25'sd0;
                4'd1:  k = 25'sd3488179;
                4'd2:  k = 25'sd6823909;
                4'd3:  k = 25'sd9861400;
                4'd4:  k = 25'sd12467901;
                4'd5:  k = 25'sd14529495;
                4'd6:  k = 25'sd15956081;
                4'd7:  k = 25'sd16685309;
                4'd8:  k = -25'sd16705647;
                4'd9:  k = -25'sd16136757;
                4'd10: k = -25'sd15018348;
                4'd11: k = -25'sd13388507;
                4'd12: k = -25'sd11302737;
                4'd13: k = -25'sd8832066;
                4'd14: k = -25'sd6060629;
                default: k = -25'sd3082805;
            endcase
        end
        return k;
    endfunction

endpackage

[rtl/tlpc_mul.sv]
module tlpc_mul
(
    input  logic                                clk,
    input  logic signed [tlpc_pkg::LPC_W-1:0]   coef,
    input  logic signed [tlpc_pkg::SMP_W-1:0]   mult,
    output logic signed [tlpc_pkg::PH_W-1:0]    prod_hi_reg,
    output logic signed [tlpc_pkg::PL_W-1:0]    prod_lo_reg
);

    logic signed [23:0]                  coef_hi;
    logic signed [24:0]                  coef_lo;
    logic signed [tlpc_pkg::PH_W-1:0]    prod_hi_next;
    logic signed [tlpc_pkg::PL_W-1:0]    prod_lo_next;

    // Split the 48-bit coefficient into a signed upper half and an unsigned lower half.
    assign coef_hi = coef[47:24];
    assign coef_lo = $signed({1'b0, coef[23:0]});

    assign prod_hi_next = tlpc_pkg::PH_W'(coef_hi) * tlpc_pkg::PH_W'(mult);
    assign prod_lo_next = tlpc_pkg::PL_W'(coef_lo) * tlpc_pkg::PL_W'(mult);

    // Both partial products are registered.
    always_ff @(posedge clk)
    begin
        prod_hi_reg <= prod_hi_next;
        prod_lo_reg <= prod_lo_next;
    end

endmodule

[rtl/tns_lpc_allpole_filter_unit.sv]
// Sequence: a filter word issues one tap read per loaded tap (ST_FISS), drains the
// multiplier pipeline (ST_FDRN) and waits in ST_FFIN for a free output register; a load
// steps through ST_LRD, ST_LM1, ST_LW1 and ST_LW2 for each tap pair, then ST_LK.
// Throughput: one word at a time; the tap loop reads one LPC tap and one history entry
// per cycle from the two memories, feeding the shared multiplier pair.
// Reset: order zero, resolution four, history reads as zero; LPC memory is not cleared.
module tns_lpc_allpole_filter_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // coef_resolution[2:0], coef_quant[6:3], sample_in[38:7]
    input  logic [1:0]  s_tuser,   // operation[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // filtered_sample[31:0]
    output logic [0:0]  m_tuser    // saturated[0]
);

    localparam int LPC_W = tlpc_pkg::LPC_W;
    localparam int SMP_W = tlpc_pkg::SMP_W;
    localparam int IDX_W = tlpc_pkg::IDX_W;
    localparam int ORD_W = tlpc_pkg::ORD_W;
    localparam int ACC_W = tlpc_pkg::ACC_W;
    localparam int LS_W  = tlpc_pkg::PH_W + 2;
    localparam int Y_W   = ACC_W + 2;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_FISS  = 4'd1;
    localparam logic [3:0] ST_FDRN  = 4'd2;
    localparam logic [3:0] ST_FFIN  = 4'd3;
    localparam logic [3:0] ST_LRD   = 4'd4;
    localparam logic [3:0] ST_LM1   = 4'd5;
    localparam logic [3:0] ST_LW1   = 4'd6;
    localparam logic [3:0] ST_LW2   = 4'd7;
    localparam logic [3:0] ST_LK    = 4'd8;

    localparam logic signed [LPC_W-1:0] LPC_MAX = {1'b0, {(LPC_W-1){1'b1}}};
    localparam logic signed [LPC_W-1:0] LPC_MIN = {1'b1, {(LPC_W-1){1'b0}}};
    localparam logic signed [SMP_W-1:0] SMP_MAX = {1'b0, {(SMP_W-1){1'b1}}};
    localparam logic signed [SMP_W-1:0] SMP_MIN = {1'b1, {(SMP_W-1){1'b0}}};

    logic [3:0]                 state_reg, state_next;
    logic [ORD_W-1:0]           order_reg, order_next;
    logic                       res3_reg, res3_next;
    logic [ORD_W-1:0]           cnt_reg, cnt_next;
    logic [IDX_W-1:0]           hptr_reg, hptr_next;
    logic [IDX_W-1:0]           wptr_reg, wptr_next;
    logic [IDX_W-1:0]           i_reg, i_next;
    logic [IDX_W-1:0]           j_reg, j_next;
    logic [tlpc_pkg::MAX_ORDER-1:0] hvld_reg, hvld_next;
    logic                       p1_reg, p1_next;
    logic                       p2_reg;
    logic                       hval_reg;
    logic                       out_valid_reg, out_valid_next;
    logic signed [SMP_W-1:0]    out_data_reg, out_data_next;
    logic                       out_sat_reg, out_sat_next;
    logic signed [SMP_W-1:0]    x_reg, x_next;
    logic signed [tlpc_pkg::K_W-1:0] k_reg, k_next;
    logic signed [LPC_W-1:0]    a_reg, a_next;
    logic signed [LPC_W-1:0]    b_reg, b_next;
    logic signed [ACC_W-1:0]    acc_hi_reg, acc_hi_next;
    logic signed [ACC_W-1:0]    acc_lo_reg, acc_lo_next;

    // Memories and their registered read data.
    logic signed [LPC_W-1:0]    lpc_mem [tlpc_pkg::MAX_ORDER];
    logic signed [SMP_W-1:0]    hist_mem [tlpc_pkg::MAX_ORDER];
    logic signed [LPC_W-1:0]    lpc_rd0_reg, lpc_rd1_reg;
    logic signed [SMP_W-1:0]    hist_rd_reg;

    logic [IDX_W-1:0]           lpc_ra0, lpc_ra1, lpc_wa;
    logic                       lpc_we;
    logic signed [LPC_W-1:0]    lpc_wd;
    logic                       hist_we;

    logic signed [LPC_W-1:0]    mul_coef;
    logic signed [SMP_W-1:0]    mul_x;
    logic signed [tlpc_pkg::PH_W-1:0] prod_hi;
    logic signed [tlpc_pkg::PL_W-1:0] prod_lo;

    logic signed [LS_W-1:0]     lsum;
    logic signed [LPC_W-1:0]    lsat;
    logic signed [LPC_W-1:0]    lbase;
    logic signed [Y_W-1:0]      yfull;
    logic signed [ACC_W:0]      lo_rnd;

    logic                       in_acc;
    logic                       out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_sat_reg;

    // Shared multiplier pair for both the step-up recursion and the tap loop.
    always_comb
    begin
        if (state_reg == ST_LM1)
        begin
            mul_coef = lpc_rd1_reg;
            mul_x    = SMP_W'(k_reg);
        end
        else if (state_reg == ST_LW1)
        begin
            mul_coef = a_reg;
            mul_x    = SMP_W'(k_reg);
        end
        else
        begin
            mul_coef = lpc_rd0_reg;
            mul_x    = hval_reg ? hist_rd_reg : '0;
        end
    end

    tlpc_mul u_mul
    (
        .clk         (clk),
        .coef        (mul_coef),
        .mult        (mul_x),
        .prod_hi_reg (prod_hi),
        .prod_lo_reg (prod_lo)
    );

    // Step-up tap: base + k*m rounded half up, saturated to 48 bits.
    always_comb
    begin
        lbase = (state_reg == ST_LW2) ? b_reg : a_reg;
        lsum  = LS_W'(lbase) + LS_W'(prod_hi)
              + LS_W'((prod_lo + tlpc_pkg::PL_W'(25'sd8388608)) >>> 24);
        if (lsum > LS_W'(LPC_MAX))
            lsat = LPC_MAX;
        else if (lsum < LS_W'(LPC_MIN))
            lsat = LPC_MIN;
        else
            lsat = LPC_W'(lsum);
    end

    // Filter output: x minus the rounded sum of products.
    always_comb
    begin
        lo_rnd = ((ACC_W+1)'(acc_lo_reg) + (ACC_W+1)'(25'sd8388608)) >>> 24;
        yfull  = Y_W'(x_reg) - Y_W'(acc_hi_reg) - Y_W'(lo_rnd);
    end

    // Memory address and write selection.
    always_comb
    begin
        lpc_ra0 = (state_reg == ST_LRD) ? i_reg : cnt_reg[IDX_W-1:0];
        lpc_ra1 = j_reg;
        lpc_we  = 1'b0;
        lpc_wa  = i_reg;
        lpc_wd  = lsat;
        unique case (state_reg)
            ST_LW1:
            begin
                lpc_we = 1'b1;
            end
            ST_LW2:
            begin
                lpc_we = (i_reg != j_reg);
                lpc_wa = j_reg;
            end
            ST_LK:
            begin
                lpc_we = 1'b1;
                lpc_wa = order_reg[IDX_W-1:0];
                lpc_wd = LPC_W'(k_reg);
            end
            default:
            begin
                lpc_we = 1'b0;
            end
        endcase
        hist_we = (state_reg == ST_FFIN) && out_free;
    end

    always_ff @(posedge clk)
    begin
        if (lpc_we)
            lpc_mem[lpc_wa] <= lpc_wd;
        lpc_rd0_reg <= lpc_mem[lpc_ra0];
        lpc_rd1_reg <= lpc_mem[lpc_ra1];
    end

    always_ff @(posedge clk)
    begin
        if (hist_we)
            hist_mem[wptr_reg] <= out_data_next;
        hist_rd_reg <= hist_mem[hptr_reg];
    end

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        order_next     = order_reg;
        res3_next      = res3_reg;
        cnt_next       = cnt_reg;
        hptr_next      = hptr_reg;
        wptr_next      = wptr_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        hvld_next      = hvld_reg;
        p1_next        = 1'b0;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        out_sat_next   = out_sat_reg;
        x_next         = x_reg;
        k_next         = k_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        acc_hi_next    = acc_hi_reg;
        acc_lo_next    = acc_lo_reg;

        if (p2_reg)
        begin
            acc_hi_next = acc_hi_reg + ACC_W'(prod_hi);
            acc_lo_next = acc_lo_reg + ACC_W'(prod_lo);
        end

        // Saturated filter output.
        if (yfull > Y_W'(SMP_MAX))
        begin
            out_data_next = SMP_MAX;
            out_sat_next  = 1'b1;
        end
        else if (yfull < Y_W'(SMP_MIN))
        begin
            out_data_next = SMP_MIN;
            out_sat_next  = 1'b1;
        end
        else
        begin
            out_data_next = SMP_W'(yfull);
            out_sat_next  = 1'b0;
        end
        if (!hist_we)
        begin
            out_data_next = out_data_reg;
            out_sat_next  = out_sat_reg;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    unique case (s_tuser)
                        tlpc_pkg::OP_BEGIN:
                        begin
                            res3_next  = (s_tdata[2:0] == 3'd3);
                            order_next = '0;
                            hvld_next  = '0;
                        end
                        tlpc_pkg::OP_LOAD:
                        begin
                            k_next = tlpc_pkg::refl_coef(res3_reg, s_tdata[6:3]);
                            i_next = '0;
                            j_next = IDX_W'(order_reg - ORD_W'(1));
                            if (order_reg >= ORD_W'(tlpc_pkg::MAX_ORDER))
                                state_next = ST_IDLE;
                            else if (order_reg == '0)
                                state_next = ST_LK;
                            else
                                state_next = ST_LRD;
                        end
                        tlpc_pkg::OP_FILTER:
                        begin
                            x_next      = $signed(s_tdata[38:7]);
                            acc_hi_next = '0;
                            acc_lo_next = '0;
                            cnt_next    = '0;
                            hptr_next   = (wptr_reg == '0) ? IDX_W'(tlpc_pkg::MAX_ORDER - 1)
                                                           : wptr_reg - IDX_W'(1);
                            state_next  = (order_reg == '0) ? ST_FDRN : ST_FISS;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_FISS:
            begin
                p1_next   = 1'b1;
                cnt_next  = cnt_reg + ORD_W'(1);
                hptr_next = (hptr_reg == '0) ? IDX_W'(tlpc_pkg::MAX_ORDER - 1)
                                             : hptr_reg - IDX_W'(1);
                if (cnt_reg == order_reg - ORD_W'(1))
                    state_next = ST_FDRN;
            end
            ST_FDRN:
            begin
                if (!p1_reg && !p2_reg)
                    state_next = ST_FFIN;
            end
            ST_FFIN:
            begin
                if (out_free)
                begin
                    out_valid_next     = 1'b1;
                    hvld_next[wptr_reg] = 1'b1;
                    wptr_next  = (wptr_reg == IDX_W'(tlpc_pkg::MAX_ORDER - 1)) ? '0
                                                                               : wptr_reg + IDX_W'(1);
                    state_next = ST_IDLE;
                end
            end
            ST_LRD:
            begin
                state_next = ST_LM1;
            end
            ST_LM1:
            begin
                a_next     = lpc_rd0_reg;
                b_next     = lpc_rd1_reg;
                state_next = ST_LW1;
            end
            ST_LW1:
            begin
                state_next = ST_LW2;
            end
            ST_LW2:
            begin
                if ((ORD_W+1)'(i_reg) + (ORD_W+1)'(2) <= (ORD_W+1)'(j_reg))
                begin
                    i_next     = i_reg + IDX_W'(1);
                    j_next     = j_reg - IDX_W'(1);
                    state_next = ST_LRD;
                end
                else
                begin
                    state_next = ST_LK;
                end
            end
            ST_LK:
            begin
                order_next = order_reg + ORD_W'(1);
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            order_reg     <= '0;
            res3_reg      <= 1'b0;
            hvld_reg      <= '0;
            wptr_reg      <= '0;
            p1_reg        <= 1'b0;
            p2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            order_reg     <= order_next;
            res3_reg      <= res3_next;
            hvld_reg      <= hvld_next;
            wptr_reg      <= wptr_next;
            p1_reg        <= p1_next;
            p2_reg        <= p1_reg;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        cnt_reg      <= cnt_next;
        hptr_reg     <= hptr_next;
        hval_reg     <= hvld_reg[hptr_reg];
        i_reg        <= i_next;
        j_reg        <= j_next;
        out_data_reg <= out_data_next;
        out_sat_reg  <= out_sat_next;
        x_reg        <= x_next;
        k_reg        <= k_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        acc_hi_reg   <= acc_hi_next;
        acc_lo_reg   <= acc_lo_next;
    end

    // The loaded order never passes the memory depth.
    a_order_max: assert property (@(posedge clk) disable iff (!rst_n)
        order_reg <= ORD_W'(tlpc_pkg::MAX_ORDER))
        else $error("loaded order beyond maximum");

    // The tap loop only reads taps that a load has written.
    a_tap_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FISS) |-> (cnt_reg < order_reg))
        else $error("tap read beyond loaded order");

    // A pair of the step-up recursion never crosses over.
    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LRD) |-> (i_reg <= j_reg))
        else $error("step-up pair out of order");

    // A finished sample waits while the output register is still occupied.
    a_fin_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FFIN && out_valid_reg && !m_tready) |=> (state_reg == ST_FFIN))
        else $error("result overwritten before it was taken");

endmodule

[tb/tb_tns_lpc_allpole_filter_unit.sv]
module tb_tns_lpc_allpole_filter_unit;

    timeunit 1ns;
    timeprecision 1ps;

    // Operation code that the block must ignore.
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int         HOLD_CYCLES = 300;
    localparam int         DRAIN_CYCLES = 100;

    typedef struct packed {
        logic [1:0]  op;
        logic [2:0]  res;
        logic [3:0]  quant;
        logic [31:0] sample;
    } tns_word_t;

    typedef struct packed {
        logic [31:0] y;
        logic        sat;
    } tns_out_t;

    // Reflection coefficients in Q.24 for each quantized index.
    localparam int REFL3 [8] = '{0, 7279361, 13116956, 16356576,
                                 -16522332, -14529495, -10784187, -5738146};
    localparam int REFL4 [16] = '{0, 3488179, 6823909, 9861400, 12467901, 14529495,
                                  15956081, 16685309, -16705647, -16136757, -15018348,
                                  -13388507, -11302737, -8832066, -6060629, -3082805};

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // coef_resolution[2:0], coef_quant[6:3], sample_in[38:7]
    logic [1:0]  s_tuser;   // operation[1:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // filtered_sample[31:0]
    logic [0:0]  m_tuser;   // saturated[0]

    tns_word_t pending_words[$];
    tns_out_t  expected_outs[$];
    int        idle_pct;
    int        stall_pct;
    int        hold_req;
    int        hold_done;
    int        hold_cnt;
    int        errors;
    int        n_filter;
    int        n_load;
    int        n_begin;
    int        n_sat;
    logic      took;

    // Predictor state.
    longint    lpc_taps [tlpc_pkg::MAX_ORDER];
    int        y_hist [tlpc_pkg::MAX_ORDER];
    int        tap_count;
    logic [2:0] coef_res;

    tns_lpc_allpole_filter_unit u_top
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Free-running clock.
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic longint clamp48(input longint v);
        if (v > (64'sd1 <<< 47) - 1)
            return (64'sd1 <<< 47) - 1;
        if (v < -(64'sd1 <<< 47))
            return -(64'sd1 <<< 47);
        return v;
    endfunction

    // Round-half-up of k * m / 2^24, split so that no product overflows.
    function automatic longint scale_q24(input longint k, input longint m);
        longint hi;
        longint lo;
        hi = m >>> 24;
        lo = m - (hi <<< 24);
        return k * hi + ((k * lo + (64'sd1 <<< 23)) >>> 24);
    endfunction

    // Advances the filter state by one accepted word.
    task automatic tns_predict(input tns_word_t w);
        longint k;
        longint next_taps [tlpc_pkg::MAX_ORDER];
        longint x;
        longint acc_hi;
        longint acc_lo;
        longint hi;
        longint y;
        tns_out_t r;
        case (w.op)
            tlpc_pkg::OP_BEGIN:
            begin
                n_begin++;
                coef_res = w.res;
                tap_count = 0;
                for (int i = 0; i < tlpc_pkg::MAX_ORDER; i++)
                    y_hist[i] = 0;
            end
            tlpc_pkg::OP_LOAD:
            begin
                if (tap_count < tlpc_pkg::MAX_ORDER)
                begin
                    n_load++;
                    k = (coef_res == 3'd3) ? REFL3[w.quant[2:0]] : REFL4[w.quant];
                    for (int i = 0; i < tap_count; i++)
                        next_taps[i] = clamp48(lpc_taps[i]
                                       + scale_q24(k, lpc_taps[tap_count - 1 - i]));
                    for (int i = 0; i < tap_count; i++)
                        lpc_taps[i] = next_taps[i];
                    lpc_taps[tap_count] = k;
                    tap_count++;
                end
            end
            tlpc_pkg::OP_FILTER:
            begin
                n_filter++;
                x = longint'($signed(w.sample));
                acc_hi = 0;
                acc_lo = 0;
                for (int i = 0; i < tap_count; i++)
                begin
                    hi = lpc_taps[i] >>> 24;
                    acc_hi += hi * longint'(y_hist[i]);
                    acc_lo += (lpc_taps[i] - (hi <<< 24)) * longint'(y_hist[i]);
                end
                y = x - acc_hi - ((acc_lo + (64'sd1 <<< 23)) >>> 24);
                r.sat = 1'b0;
                if (y > 64'sd2147483647)
                begin
                    y = 64'sd2147483647;
                    r.sat = 1'b1;
                end
                if (y < -64'sd2147483648)
                begin
                    y = -64'sd2147483648;
                    r.sat = 1'b1;
                end
                if (r.sat)
                    n_sat++;
                r.y = y[31:0];
                for (int i = tlpc_pkg::MAX_ORDER - 1; i > 0; i--)
                    y_hist[i] = y_hist[i - 1];
                y_hist[0] = int'(y[31:0]);
                expected_outs.push_back(r);
            end
            default:
            begin
            end
        endcase
    endtask

    // Sender: offers the next word at the falling edge, holding it until taken.
    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || took))
        begin
            if (pending_words.size() == 0 || $urandom_range(99) < idle_pct)
                s_tvalid <= 1'b0;
            else
            begin
                tns_word_t w;
                w = pending_words.pop_front();
                s_tdata <= {1'b0, w.sample, w.quant, w.res};
                s_tuser <= w.op;
                s_tvalid <= 1'b1;
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off when one is requested.
    always @(negedge clk)
    begin
        if (hold_req != hold_done)
        begin
            hold_done = hold_req;
            hold_cnt = HOLD_CYCLES;
        end
        if (hold_cnt > 0)
        begin
            hold_cnt--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Input side: every accepted word updates the predictor.
    always @(posedge clk)
    begin
        took <= s_tvalid && s_tready;
        if (rst_n && s_tvalid && s_tready)
            tns_predict(tns_word_t'{s_tuser, s_tdata[2:0], s_tdata[6:3], s_tdata[38:7]});
    end

    // Output side: every accepted word is checked against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_outs.size() == 0)
            begin
                $error("unexpected output word: filtered_sample=%0d saturated=%0d",
                       $signed(m_tdata), m_tuser);
                errors++;
            end
            else
            begin
                tns_out_t e;
                e = expected_outs.pop_front();
                if (m_tdata !== e.y)
                begin
                    $error("filtered_sample: expected %0d, actual %0d",
                           $signed(e.y), $signed(m_tdata));
                    errors++;
                end
                if (m_tuser[0] !== e.sat)
                begin
                    $error("saturated: expected %0d, actual %0d", e.sat, m_tuser[0]);
                    errors++;
                end
            end
        end
    end

    function automatic tns_word_t mk(input logic [1:0] op, input logic [2:0] res,
                                     input logic [3:0] q, input logic [31:0] x);
        return tns_word_t'{op, res, q, x};
    endfunction

    function automatic logic [31:0] rand_sample();
        int sel;
        sel = $urandom_range(9);
        if (sel < 2)
            return $urandom();
        if (sel < 3)
            return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
        return 32'($signed($urandom_range(2000000)) - 1000000);
    endfunction

    // One filter setup: at times an unused word, then begin, a run of loads, then a run of samples.
    task automatic queue_frame();
        logic [2:0] res;
        int n_loads;
        int n_samples;
        res = ($urandom_range(9) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(4, 3));
        if ($urandom_range(9) == 0)
            pending_words.push_back(mk(OP_UNUSED, 3'($urandom()), 4'($urandom()), $urandom()));
        pending_words.push_back(mk(tlpc_pkg::OP_BEGIN, res, 4'($urandom()), $urandom()));
        n_loads = ($urandom_range(7) == 0) ? $urandom_range(24, 18) : $urandom_range(8);
        for (int i = 0; i < n_loads; i++)
            pending_words.push_back(mk(tlpc_pkg::OP_LOAD, 3'($urandom()), 4'($urandom()),
                                       $urandom()));
        n_samples = $urandom_range(20, 3);
        for (int i = 0; i < n_samples; i++)
            pending_words.push_back(mk(tlpc_pkg::OP_FILTER, 3'($urandom()), 4'($urandom()),
                                       rand_sample()));
    endtask

    task automatic drain();
        while (pending_words.size() != 0 || s_tvalid || expected_outs.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    initial
    begin
        int words_sent;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = tlpc_pkg::OP_BEGIN;
        m_tready = 1'b0;
        took = 1'b0;
        idle_pct = 0;
        stall_pct = 0;
        hold_req = 0;
        hold_done = 0;
        hold_cnt = 0;
        errors = 0;
        n_filter = 0;
        n_load = 0;
        n_begin = 0;
        n_sat = 0;
        tap_count = 0;
        coef_res = 3'd4;
        for (int i = 0; i < tlpc_pkg::MAX_ORDER; i++)
        begin
            lpc_taps[i] = 0;
            y_hist[i] = 0;
        end
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        // Directed words: no taps after reset, both resolutions, index extremes,
        // an index wider than resolution three, an odd resolution, the unused code.
        pending_words.push_back(mk(tlpc_pkg::OP_FILTER, 3'd0, 4'd0, 32'h7fffffff));
        pending_words.push_back(mk(tlpc_pkg::OP_BEGIN, 3'd3, 4'd0, 32'd0));
        pending_words.push_back(mk(tlpc_pkg::OP_LOAD, 3'd0, 4'd7, 32'd0));
        pending_words.push_back(mk(tlpc_pkg::OP_LOAD, 3'd0, 4'd12, 32'd0));
        pending_words.push_back(mk(tlpc_pkg::OP_LOAD, 3'd0, 4'd3, 32'd0));
        pending_words.push_back(mk(tlpc_pkg::OP_FILTER, 3'd0, 4'd0, 32'h00010000));
        pending_words.push_back(mk(tlpc_pkg::OP_FILTER, 3'd0, 4'd0, 32'h80000000));
        pending_words.push_back(mk(tlpc_pkg::OP_FILTER, 3'd0, 4'd0, 32'h7fffffff));
        pending_words.push_back(mk(tlpc_pkg::OP_BEGIN, 3'd4, 4'd0, 32'd0));
        pending_words.push_back(mk(tlpc_pkg::OP_LOAD, 3'd0, 4'd7, 32'd0));
        pending_words.push_back(mk(tlpc_pkg::OP_LOAD, 3'd0, 4'd8, 32'd0));
        pending_words.push_back(mk(tlpc_pkg::OP_LOAD, 3'd0, 4'd15, 32'd0));
        pending_words.push_back(mk(tlpc_pkg::OP_FILTER, 3'd0, 4'd0, 32'h80000000));
        pending_words.push_back(mk(tlpc_pkg::OP_FILTER, 3'd0, 4'd0, 32'h7fffffff));
        pending_words.push_back(mk(tlpc_pkg::OP_FILTER, 3'd0, 4'd0, 32'd0));
        pending_words.push_back(mk(OP_UNUSED, 3'd7, 4'd15, 32'hffffffff));
        pending_words.push_back(mk(tlpc_pkg::OP_BEGIN, 3'd7, 4'd0, 32'd0));
        pending_words.push_back(mk(tlpc_pkg::OP_FILTER, 3'd0, 4'd0, 32'hffffffff));
        pending_words.push_back(mk(tlpc_pkg::OP_LOAD, 3'd0, 4'd1, 32'd0));
        pending_words.push_back(mk(tlpc_pkg::OP_FILTER, 3'd0, 4'd0, 32'h12345678));
        pending_words.push_back(mk(tlpc_pkg::OP_BEGIN, 3'd0, 4'd0, 32'd0));
        pending_words.push_back(mk(tlpc_pkg::OP_LOAD, 3'd0, 4'd2, 32'd0));
        pending_words.push_back(mk(tlpc_pkg::OP_FILTER, 3'd0, 4'd0, 32'h00020000));
        drain();

        // Random phases: free flow with a long output hold-off, idle sender,
        // stalling receiver, then both.
        for (int ph = 0; ph < 4; ph++)
        begin
            idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 69 : 16) : 0;
            stall_pct = (ph == 2 || ph == 3) ? ((ph == 2) ? 69 : 16) : 0;
            words_sent = 0;
            while (words_sent < 150)
            begin
                queue_frame();
                words_sent = words_sent + pending_words.size();
                if (ph == 0 && hold_req == 0)
                    hold_req = 1;
                while (pending_words.size() != 0)
                    @(negedge clk);
            end
            drain();
        end

        $display("Covered %0d begin, %0d load and %0d filter words, %0d saturated outputs,",
                 n_begin, n_load, n_filter, n_sat);
        $display("across free flow, a long output hold-off and random idle and stall phases.");
        if (errors == 0 && expected_outs.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #8ms;
        $display("FAIL");
        $finish;
    end

endmodule

[filelist.f]
rtl/tlpc_pkg.sv
rtl/tlpc_mul.sv
rtl/tns_lpc_allpole_filter_unit.sv
tb/tb_tns_lpc_allpole_filter_unit.sv
